>>> rtl/bdth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdth_pkg
// Shared types and constants for the debounced button with tap and hold
// detection.
// ----------------------------------------------------------------------------
package bdth_pkg;

  localparam int LIMIT_W   = 16;
  localparam int STAMP_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT     = 1'b1;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_LIMIT_RST = 16'd50;
  localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST     = 16'd500;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_OFF     = 3'd1,
    PH_ON_DEB  = 3'd2,
    PH_ON      = 3'd3,
    PH_OFF_DEB = 3'd4
  } deb_phase_t;

  typedef enum logic [1:0] {
    BS_UNPRESSED = 2'd0,
    BS_PRESSED   = 2'd1,
    BS_HOLD      = 2'd2
  } btn_state_t;

  typedef struct packed {
    logic       is_down;
    logic       is_held;
    logic       just_pressed;
    logic       tap_pulse;
    logic       hold_pulse;
    logic       state_changed;
    logic [1:0] new_button_state;
  } bdth_res_t;

endpackage

>>> rtl/bdth_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdth_core
// Debounce machine, button state and change stamp, advanced once per beat.
// ----------------------------------------------------------------------------
module bdth_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic                      pin_level,
  input  logic [bdth_pkg::STAMP_W-1:0] now_time,
  input  logic [bdth_pkg::LIMIT_W-1:0] debounce_limit,
  input  logic [bdth_pkg::LIMIT_W-1:0] hold_limit,
  output bdth_pkg::bdth_res_t       res
);
  import bdth_pkg::*;

  deb_phase_t         phase_r, phase_nxt;
  btn_state_t         bstate_r, bstate_nxt;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt;
  logic               prev_level_r;
  logic               press_flag_r, press_flag_nxt;
  logic               level_changed;
  logic [STAMP_W-1:0] elapsed;
  logic               deb_done;
  logic               hold_done;
  logic               tap;
  logic               hold;
  logic               chg;

  assign level_changed = (pin_level != prev_level_r);
  assign stamp_nxt     = level_changed ? now_time : stamp_r;
  // A fresh level change restarts the interval at zero.
  assign elapsed       = level_changed ? '0 : (now_time - stamp_r);
  assign deb_done      = elapsed > {{(STAMP_W-LIMIT_W){1'b0}}, debounce_limit};
  assign hold_done     = elapsed > {{(STAMP_W-LIMIT_W){1'b0}}, hold_limit};

  always_comb begin
    phase_nxt      = phase_r;
    bstate_nxt     = bstate_r;
    press_flag_nxt = press_flag_r;
    tap            = 1'b0;
    hold           = 1'b0;
    chg            = 1'b0;
    case (phase_r)
      PH_OFF: begin
        if (!pin_level) begin
          phase_nxt      = PH_ON_DEB;
          bstate_nxt     = BS_PRESSED;
          chg            = 1'b1;
          press_flag_nxt = 1'b1;
        end
      end
      PH_ON_DEB: begin
        press_flag_nxt = 1'b0;
        if (deb_done) begin
          phase_nxt = PH_ON;
        end
      end
      PH_ON: begin
        if (pin_level) begin
          phase_nxt = PH_OFF_DEB;
          tap       = (bstate_r != BS_HOLD);
        end else if (bstate_r != BS_HOLD && hold_done) begin
          bstate_nxt = BS_HOLD;
          chg        = 1'b1;
          hold       = 1'b1;
        end
      end
      PH_OFF_DEB: begin
        if (deb_done) begin
          phase_nxt  = PH_OFF;
          bstate_nxt = BS_UNPRESSED;
          chg        = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_OFF;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bstate_r     <= BS_UNPRESSED;
      stamp_r      <= '0;
      prev_level_r <= 1'b0;
      press_flag_r <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      bstate_r     <= bstate_nxt;
      stamp_r      <= stamp_nxt;
      prev_level_r <= pin_level;
      press_flag_r <= press_flag_nxt;
    end
  end

  always_comb begin
    res.is_down          = (bstate_nxt == BS_PRESSED);
    res.is_held          = (bstate_nxt == BS_HOLD);
    res.just_pressed     = press_flag_nxt;
    res.tap_pulse        = tap;
    res.hold_pulse       = hold;
    res.state_changed    = chg;
    res.new_button_state = chg ? bstate_nxt : BS_UNPRESSED;
  end

  // A release cannot be a tap and a hold in the same beat.
  a_tap_hold_excl: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(res.tap_pulse && res.hold_pulse))
    else $error("tap and hold pulse in the same beat");

  // An accepted press always raises the just-pressed flag.
  a_press_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && phase_r == PH_OFF && !pin_level) |=> press_flag_r)
    else $error("press accepted without just-pressed flag");

  // A hold is only ever entered from a steady press in the on phase.
  a_hold_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.hold_pulse) |-> (phase_r == PH_ON && !pin_level))
    else $error("hold reported outside a steady press");

  // Pressed and hold are never reported together.
  a_down_held: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |-> !(res.is_down && res.is_held))
    else $error("button both down and held");

endmodule

>>> rtl/button_debounce_tap_hold_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_tap_hold_unit
// Debounced active-low button with tap and hold pulses.
// Each accepted beat passes from the input register through the state
// update into the result register once the result slot is free or drains.
// Throughput: one beat per cycle unless the result side stalls; the update
// is one subtract and two compares between input and result registers.
// Reset clears the debounce phase to idle, the button state to unpressed, the
// change stamp, level and flags to zero, and loads limits 50 and 500.
// ----------------------------------------------------------------------------
module button_debounce_tap_hold_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bdth_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdth_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_pin_level,
  input  logic [bdth_pkg::STAMP_W-1:0]   in_now_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_is_down,
  output logic                           out_is_held,
  output logic                           out_just_pressed,
  output logic                           out_tap_pulse,
  output logic                           out_hold_pulse,
  output logic                           out_state_changed,
  output logic [1:0]                     out_new_button_state
);
  import bdth_pkg::*;

  logic [LIMIT_W-1:0] debounce_limit_r;
  logic [LIMIT_W-1:0] hold_limit_r;
  logic               in_valid_r, in_valid_nxt;
  logic               pin_level_r;
  logic [STAMP_W-1:0] now_time_r;
  logic               out_valid_r, out_valid_nxt;
  bdth_res_t          res;
  bdth_res_t          res_r;
  logic               in_take;
  logic               advance;

  // The held beat moves on whenever the result slot is free or being drained.
  assign advance      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = in_valid_r && !advance;
  assign in_take      = in_valid && !in_stall;
  assign in_valid_nxt = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_limit_r <= DEBOUNCE_LIMIT_RST;
      hold_limit_r     <= HOLD_LIMIT_RST;
      in_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DEBOUNCE_LIMIT: debounce_limit_r <= cfg_wdata;
          CFG_HOLD_LIMIT:     hold_limit_r     <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pin_level_r <= in_pin_level;
      now_time_r  <= in_now_time;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  bdth_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (advance),
    .pin_level      (pin_level_r),
    .now_time       (now_time_r),
    .debounce_limit (debounce_limit_r),
    .hold_limit     (hold_limit_r),
    .res            (res)
  );

  assign out_valid            = out_valid_r;
  assign out_is_down          = res_r.is_down;
  assign out_is_held          = res_r.is_held;
  assign out_just_pressed     = res_r.just_pressed;
  assign out_tap_pulse        = res_r.tap_pulse;
  assign out_hold_pulse       = res_r.hold_pulse;
  assign out_state_changed    = res_r.state_changed;
  assign out_new_button_state = res_r.new_button_state;

endmodule

>>> sim/button_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_checker
// Watches the sample and result channels of the debounced button, predicts
// the tap, hold and state-change events of every accepted sample beat and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module button_event_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bdth_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdth_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_pin_level,
  input  logic [bdth_pkg::STAMP_W-1:0]   in_now_time,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           out_is_down,
  input  logic                           out_is_held,
  input  logic                           out_just_pressed,
  input  logic                           out_tap_pulse,
  input  logic                           out_hold_pulse,
  input  logic                           out_state_changed,
  input  logic [1:0]                     out_new_button_state,
  output int                             outstanding,
  output int                             fail_count
);
  import bdth_pkg::*;

  localparam int REPORT_MAX = 10;

  logic [LIMIT_W-1:0] deb_lim;
  logic [LIMIT_W-1:0] hold_lim;
  deb_phase_t         phase;
  btn_state_t         btn;
  logic [STAMP_W-1:0] stamp;
  logic               prev_lvl;
  logic               press_flag;

  bdth_res_t expected_events[$];
  int        result_count;
  int        reported;

  function automatic bdth_res_t advance_button(input logic lvl,
                                               input logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] span;
    bdth_res_t          ev;
    ev = '0;
    if (lvl != prev_lvl) begin
      stamp = now;
    end
    span = now - stamp;
    case (phase)
      PH_OFF: begin
        if (!lvl) begin
          phase = PH_ON_DEB;
          btn = BS_PRESSED;
          ev.state_changed = 1'b1;
          ev.new_button_state = BS_PRESSED;
          press_flag = 1'b1;
        end
      end
      PH_ON_DEB: begin
        press_flag = 1'b0;
        if (span > deb_lim) begin
          phase = PH_ON;
        end
      end
      PH_ON: begin
        if (lvl) begin
          phase = PH_OFF_DEB;
          if (btn != BS_HOLD) begin
            ev.tap_pulse = 1'b1;
          end
        end else if (btn != BS_HOLD && span > hold_lim) begin
          btn = BS_HOLD;
          ev.hold_pulse = 1'b1;
          ev.state_changed = 1'b1;
          ev.new_button_state = BS_HOLD;
        end
      end
      PH_OFF_DEB: begin
        if (span > deb_lim) begin
          phase = PH_OFF;
          btn = BS_UNPRESSED;
          ev.state_changed = 1'b1;
          ev.new_button_state = BS_UNPRESSED;
        end
      end
      // Idle and the unused codes all fall through to the off phase.
      default: begin
        phase = PH_OFF;
      end
    endcase
    prev_lvl = lvl;
    ev.is_down = (btn == BS_PRESSED);
    ev.is_held = (btn == BS_HOLD);
    ev.just_pressed = press_flag;
    return ev;
  endfunction

  always @(posedge clk) begin
    bdth_res_t got;
    bdth_res_t want;
    if (!rst_n) begin
      deb_lim = DEBOUNCE_LIMIT_RST;
      hold_lim = HOLD_LIMIT_RST;
      phase = PH_IDLE;
      btn = BS_UNPRESSED;
      stamp = '0;
      prev_lvl = 1'b0;
      press_flag = 1'b0;
      expected_events.delete();
      result_count = 0;
      reported = 0;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_DEBOUNCE_LIMIT: deb_lim = cfg_wdata;
          CFG_HOLD_LIMIT:     hold_lim = cfg_wdata;
          default:            ;
        endcase
      end
      // Results are matched before this edge's sample is predicted, so a
      // stray result can never pair up with a beat accepted at the same edge.
      if (out_valid && !out_stall) begin
        got = {out_is_down, out_is_held, out_just_pressed, out_tap_pulse,
               out_hold_pulse, out_state_changed, out_new_button_state};
        if (expected_events.size() == 0) begin
          fail_count <= fail_count + 1;
          if (reported < REPORT_MAX) begin
            $display("result beat %0d arrived with nothing expected: %p",
                     result_count, got);
          end
          reported++;
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (reported < REPORT_MAX) begin
              $display("result beat %0d mismatch", result_count);
              $display("  expected down=%b held=%b just=%b tap=%b hold=%b chg=%b st=%0d",
                       want.is_down, want.is_held, want.just_pressed,
                       want.tap_pulse, want.hold_pulse, want.state_changed,
                       want.new_button_state);
              $display("  actual   down=%b held=%b just=%b tap=%b hold=%b chg=%b st=%0d",
                       got.is_down, got.is_held, got.just_pressed,
                       got.tap_pulse, got.hold_pulse, got.state_changed,
                       got.new_button_state);
            end
            reported++;
          end
        end
        result_count++;
      end
      if (in_valid && !in_stall) begin
        expected_events.push_back(advance_button(in_pin_level, in_now_time));
      end
      outstanding <= expected_events.size();
    end
  end

endmodule

>>> sim/button_debounce_tap_hold_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_debounce_tap_hold_unit_test
// Drives button samples with structured timestamps (press, bounce, long
// hold, release, wrap and random noise) through several limit settings,
// with random gaps and stalls on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module button_debounce_tap_hold_unit_test;
  import bdth_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int SQUEEZE_CYCLES = 60;
  localparam int PHASE_BEATS    = 200;
  localparam int NUM_SETTINGS   = 7;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIMIT_W-1:0]   cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_pin_level;
  logic [STAMP_W-1:0]   in_now_time;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_is_down;
  logic                 out_is_held;
  logic                 out_just_pressed;
  logic                 out_tap_pulse;
  logic                 out_hold_pulse;
  logic                 out_state_changed;
  logic [1:0]           out_new_button_state;

  int outstanding;
  int fail_count;
  int idle_cycles = 0;
  int phase_beats = 0;
  int steady_beats = 0;
  int deb_lim;
  int hold_lim;
  logic squeeze = 1'b0;
  logic [STAMP_W-1:0] tick;

  int unsigned deb_settings[NUM_SETTINGS]  = '{0, 65535, 2, 50, 65535, 0, 7};
  int unsigned hold_settings[NUM_SETTINGS] = '{0, 65535, 12, 500, 0, 65535, 40};

  button_debounce_tap_hold_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pin_level         (in_pin_level),
    .in_now_time          (in_now_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_is_down          (out_is_down),
    .out_is_held          (out_is_held),
    .out_just_pressed     (out_just_pressed),
    .out_tap_pulse        (out_tap_pulse),
    .out_hold_pulse       (out_hold_pulse),
    .out_state_changed    (out_state_changed),
    .out_new_button_state (out_new_button_state)
  );

  button_event_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_pin_level         (in_pin_level),
    .in_now_time          (in_now_time),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_is_down          (out_is_down),
    .out_is_held          (out_is_held),
    .out_just_pressed     (out_just_pressed),
    .out_tap_pulse        (out_tap_pulse),
    .out_hold_pulse       (out_hold_pulse),
    .out_state_changed    (out_state_changed),
    .out_new_button_state (out_new_button_state),
    .outstanding          (outstanding),
    .fail_count           (fail_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: short and long stalls, quiet stretches, and one long
  // hold-off per limit setting so the block backs up into its input.
  initial begin
    forever begin
      int pick;
      pick = $urandom_range(0, 99);
      if (squeeze) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze = 1'b0;
      end else if (pick < 60) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else if (pick < 90) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 30)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (squeeze) begin
      return 0;
    end
    if (steady_beats > 0) begin
      steady_beats--;
      return 0;
    end
    if (pick < 5) begin
      steady_beats = $urandom_range(10, 40);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Writes both limits on back-to-back edges while the block is idle.
  task automatic write_limits(input int unsigned deb, input int unsigned hold);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DEBOUNCE_LIMIT;
    cfg_wdata <= deb[LIMIT_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_HOLD_LIMIT;
    cfg_wdata <= hold[LIMIT_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    deb_lim = deb;
    hold_lim = hold;
  endtask

  task automatic send_beat(input logic lvl, input logic [STAMP_W-1:0] now);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pin_level <= lvl;
    in_now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    phase_beats++;
  endtask

  // One press with optional bounce and glitches, then a release, or a burst of
  // random beats; the time step scale decides if debounce and hold limits get crossed.
  task automatic press_cycle();
    int scale;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 4)) send_beat(1'($urandom_range(0, 1)), $urandom);
    end else begin
      case ($urandom_range(0, 2))
        0:       scale = 3;
        1:       scale = deb_lim / 2 + 2;
        default: scale = hold_lim / 3 + 2;
      endcase
      repeat ($urandom_range(0, 3)) begin
        tick += $urandom_range(0, 2);
        send_beat(1'($urandom_range(0, 1)), tick);
      end
      repeat ($urandom_range(1, 8)) begin
        tick += $urandom_range(0, scale);
        send_beat($urandom_range(0, 9) == 0, tick);
      end
      repeat ($urandom_range(1, 6)) begin
        tick += $urandom_range(0, scale);
        send_beat(1'b1, tick);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [STAMP_W-1:0] t0;
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_DEBOUNCE_LIMIT;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_pin_level <= 1'b0;
    in_now_time <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk with small limits; the timestamps wrap through zero
    // in the middle of a long press, before it becomes a hold.
    write_limits(4, 10);
    t0 = 32'hFFFF_FFF8;
    send_beat(1'b1, t0);
    send_beat(1'b1, t0 + 1);
    send_beat(1'b0, t0 + 2);
    send_beat(1'b0, t0 + 4);
    send_beat(1'b0, t0 + 6);
    send_beat(1'b0, t0 + 7);
    send_beat(1'b0, t0 + 12);
    send_beat(1'b0, t0 + 13);
    send_beat(1'b0, t0 + 20);
    send_beat(1'b1, t0 + 21);
    send_beat(1'b0, t0 + 22);
    send_beat(1'b0, t0 + 26);
    send_beat(1'b0, t0 + 27);
    send_beat(1'b0, t0 + 28);
    send_beat(1'b1, t0 + 29);
    send_beat(1'b1, t0 + 40);
    send_beat(1'b1, t0 + 41);
    send_beat(1'b1, t0 + 46);
    send_beat(1'b1, 32'h0000_0000);
    send_beat(1'b0, 32'hFFFF_FFFF);
    send_beat(1'b0, 32'h0000_0000);
    send_beat(1'b0, 32'h7FFF_FFFF);
    send_beat(1'b1, 32'h8000_0000);
    drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      write_limits(deb_settings[s], hold_settings[s]);
      tick = $urandom;
      squeeze = 1'b1;
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) press_cycle();
      drain();
    end

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> button_debounce_tap_hold_unit.f
rtl/bdth_pkg.sv
rtl/bdth_core.sv
rtl/button_debounce_tap_hold_unit.sv
sim/button_event_checker.sv
sim/button_debounce_tap_hold_unit_test.sv
